[rtl/slpt_pkg.sv]
// Package for the status LED priority timer: shared types and constants.
// Used by the request and CSR interfaces, the engine and the top level.
`timescale 1ns / 1ps
`default_nettype none

package slpt_pkg;

   localparam int TIME_BITS = 32;
   localparam int CFG_BITS  = 32;

   localparam logic [TIME_BITS-1:0] BLINK_HALF_MS = TIME_BITS'(500);

   typedef enum logic [0:0] {
      CSR_AFTERGLOW = 1'b0,
      CSR_STANDBY   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                 detect_level;
      logic                 fault_level;
      logic [TIME_BITS-1:0] time_now;
   } item_type;

   typedef struct packed {
      logic red_led;
      logic green_led;
   } led_type;

   typedef struct packed {
      logic                valid;
      csr_index_type       index;
      logic [CFG_BITS-1:0] data;
   } csr_wr_type;

endpackage

`default_nettype wire

[rtl/slpt_req_if.sv]
// Input channel of the status LED priority timer: levels and timestamp.
// Depends on slpt_pkg for the timestamp width.
`timescale 1ns / 1ps
`default_nettype none

interface slpt_req_if;
   logic                          valid;
   logic                          ready;
   logic                          detect_level;
   logic                          fault_level;
   logic [slpt_pkg::TIME_BITS-1:0] time_now;

   modport source (output valid, detect_level, fault_level, time_now, input ready);
   modport sink   (input valid, detect_level, fault_level, time_now, output ready);
endinterface

`default_nettype wire

[rtl/slpt_rsp_if.sv]
// Result channel of the status LED priority timer: red and green LED drive.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface slpt_rsp_if;
   logic valid;
   logic ready;
   logic red_led;
   logic green_led;

   modport source (output valid, red_led, green_led, input ready);
   modport sink   (input valid, red_led, green_led, output ready);
endinterface

`default_nettype wire

[rtl/slpt_csr_if.sv]
// Configuration write channel of the status LED priority timer.
// Depends on slpt_pkg for the index type and data width.
`timescale 1ns / 1ps
`default_nettype none

interface slpt_csr_if;
   logic                           valid;
   logic                           ready;
   slpt_pkg::csr_index_type        index;
   logic [slpt_pkg::CFG_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/slpt_engine.sv]
// Timing engine of the status LED priority timer: edge detection, blink,
// afterglow and standby timers, and the LED priority decision. Uses slpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slpt_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_en,
   input  wire slpt_pkg::item_type  item,
   input  wire slpt_pkg::csr_wr_type csr_wr,
   output slpt_pkg::led_type        led
);

   logic [slpt_pkg::TIME_BITS-1:0] afterglow_len_ff;
   logic [slpt_pkg::TIME_BITS-1:0] standby_len_ff;
   logic                           detect_prev_ff, detect_prev_in;
   logic                           fault_prev_ff, fault_prev_in;
   logic                           afterglow_on_ff, afterglow_on_in;
   logic [slpt_pkg::TIME_BITS-1:0] afterglow_start_ff, afterglow_start_in;
   logic [slpt_pkg::TIME_BITS-1:0] idle_start_ff, idle_start_in;
   logic                           blink_phase_ff, blink_phase_in;
   logic [slpt_pkg::TIME_BITS-1:0] blink_start_ff, blink_start_in;
   logic [slpt_pkg::TIME_BITS-1:0] last_time_ff;
   logic [slpt_pkg::TIME_BITS-1:0] now;

   assign now               = item.time_now;

   always_comb begin
      detect_prev_in     = detect_prev_ff;
      fault_prev_in      = fault_prev_ff;
      afterglow_on_in    = afterglow_on_ff;
      afterglow_start_in = afterglow_start_ff;
      idle_start_in      = idle_start_ff;
      blink_phase_in     = blink_phase_ff;
      blink_start_in     = blink_start_ff;
      led                = '0;

      if (item.fault_level != fault_prev_ff) begin
         fault_prev_in  = item.fault_level;
         blink_phase_in = 1'b0;
         blink_start_in = now;
      end

      if (item.detect_level != detect_prev_ff) begin
         if (!item.detect_level) begin
            afterglow_on_in    = (afterglow_len_ff != '0);
            afterglow_start_in = now;
            if (afterglow_len_ff == '0) begin
               idle_start_in = now;
            end
         end else begin
            afterglow_on_in = 1'b0;
            idle_start_in   = now;
         end
         detect_prev_in = item.detect_level;
      end

      if (fault_prev_in) begin
         if ((now - blink_start_in) >= slpt_pkg::BLINK_HALF_MS) begin
            blink_start_in = now;
            blink_phase_in = !blink_phase_in;
         end
         led.red_led = blink_phase_in;
      end else if (detect_prev_in) begin
         led.red_led = 1'b1;
      end else begin
         if (afterglow_on_in && ((now - afterglow_start_in) >= afterglow_len_ff)) begin
            afterglow_on_in = 1'b0;
            idle_start_in   = now;
         end
         if (afterglow_on_in) begin
            led.red_led = 1'b1;
         end else begin
            led.green_led = (standby_len_ff == '0) ||
                            ((now - idle_start_in) < standby_len_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         afterglow_len_ff   <= '0;
         standby_len_ff     <= '0;
         detect_prev_ff     <= 1'b0;
         fault_prev_ff      <= 1'b0;
         afterglow_on_ff    <= 1'b0;
         afterglow_start_ff <= '0;
         idle_start_ff      <= '0;
         blink_phase_ff     <= 1'b0;
         blink_start_ff     <= '0;
         last_time_ff       <= '0;
      end else if (step_en) begin
         detect_prev_ff     <= detect_prev_in;
         fault_prev_ff      <= fault_prev_in;
         afterglow_on_ff    <= afterglow_on_in;
         afterglow_start_ff <= afterglow_start_in;
         idle_start_ff      <= idle_start_in;
         blink_phase_ff     <= blink_phase_in;
         blink_start_ff     <= blink_start_in;
         last_time_ff       <= now;
      end else if (csr_wr.valid) begin
         unique case (csr_wr.index)
            slpt_pkg::CSR_AFTERGLOW: begin
               afterglow_len_ff <= csr_wr.data;
               if ((csr_wr.data == '0) && afterglow_on_ff) begin
                  afterglow_on_ff <= 1'b0;
                  idle_start_ff   <= last_time_ff;
               end
            end
            slpt_pkg::CSR_STANDBY: begin
               standby_len_ff <= csr_wr.data;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/status_led_priority_timer.sv]
// Status LED priority timer, top level: input word register, timing engine
// and result register. Depends on slpt_pkg, the three channel interfaces
// and slpt_engine.
//
// Each input word carries the detect and fault levels and a wrapping
// millisecond timestamp; each yields exactly one result word with the red
// and green LED drive. The block takes one word per cycle while results are
// taken: a word is registered on acceptance and evaluated against the timer
// state once the result register can take it; its result is then registered
// and offered. The input and result registers form a two-word pipeline, so a
// new word is taken while a finished result still waits. Configuration
// writes are always ready and must only be issued while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

module status_led_priority_timer (
   input  wire logic   clock,
   input  wire logic   reset,
   slpt_req_if.sink    req_ch,
   slpt_rsp_if.source  rsp_ch,
   slpt_csr_if.sink    csr_ch
);

   logic                 in_valid_ff;
   slpt_pkg::item_type   item_ff;
   logic                 out_valid_ff;
   slpt_pkg::led_type    led_ff;
   slpt_pkg::led_type    led_in;
   slpt_pkg::csr_wr_type csr_wr;
   logic                 advance;
   logic                 req_accept;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign csr_wr.valid = csr_ch.valid;
   assign csr_wr.index = csr_ch.index;
   assign csr_wr.data  = csr_ch.data;

   slpt_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .csr_wr  (csr_wr),
      .led     (led_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         item_ff.detect_level <= req_ch.detect_level;
         item_ff.fault_level  <= req_ch.fault_level;
         item_ff.time_now     <= req_ch.time_now;
      end
      if (advance) begin
         led_ff <= led_in;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.red_led   = led_ff.red_led;
   assign rsp_ch.green_led = led_ff.green_led;

   a_leds_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(led_ff.red_led && led_ff.green_led))
      else $error("red and green LEDs driven together");

   a_fault_no_green: assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.fault_level) |=> !led_ff.green_led)
      else $error("green LED lit while a fault is active");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> in_valid_ff)
      else $error("accepted word not held in the input register");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("evaluated word produced no result");

endmodule

`default_nettype wire
